[rtl/core/uas_cps_pkg.sv]
// ============================================================================
// uas_cps_pkg: shared types and codes of the UAS command phase sequencer
// Holds the word formats of both channels, the event and result codes and
// the small helpers that build the result list of one input word.
// ============================================================================
package uas_cps_pkg;

    // Default limits of one command.
    localparam int MaxDataBytesDefault = 4096;
    localparam int MaxCdbBytesDefault  = 16;
    localparam int QueueDepthDefault   = 4;

    // Fixed protocol constants.
    localparam logic [7:0]  UasProtocol    = 8'h62;
    localparam logic [11:0] TimeoutReset   = 12'd3000;
    localparam logic [12:0] StatusHdrBytes = 13'd4;
    localparam logic [12:0] SenseHdrBytes  = 13'd16;
    localparam logic [15:0] CmdTag         = 16'd1;

    // Configuration register indexes.
    localparam logic [1:0] CfgLinkOnline   = 2'd0;
    localparam logic [1:0] CfgLinkProtocol = 2'd1;
    localparam logic [1:0] CfgStreams      = 2'd2;
    localparam logic [1:0] CfgTimeout      = 2'd3;

    // Input event codes.
    localparam logic [2:0] CmdStart      = 3'd0;
    localparam logic [2:0] CmdCmdDone    = 3'd1;
    localparam logic [2:0] CmdDataDone   = 3'd2;
    localparam logic [2:0] CmdStatusDone = 3'd3;
    localparam logic [2:0] CmdTick       = 3'd4;
    localparam logic [2:0] CmdXportErr   = 3'd5;

    // Status IU identifiers.
    localparam logic [7:0] IuSense      = 8'd3;
    localparam logic [7:0] IuReadReady  = 8'd6;
    localparam logic [7:0] IuWriteReady = 8'd7;

    // Result actions.
    localparam logic [1:0] ActSubmit = 2'd0;
    localparam logic [1:0] ActAbort  = 2'd1;
    localparam logic [1:0] ActFinish = 2'd2;

    // Pipes.
    localparam logic [1:0] PipeCommand = 2'd0;
    localparam logic [1:0] PipeStatus  = 2'd1;
    localparam logic [1:0] PipeDataIn  = 2'd2;
    localparam logic [1:0] PipeDataOut = 2'd3;

    // Result codes.
    localparam logic [2:0] RcOk      = 3'd0;
    localparam logic [2:0] RcInvalid = 3'd1;
    localparam logic [2:0] RcIoError = 3'd2;
    localparam logic [2:0] RcTimeout = 3'd3;
    localparam logic [2:0] RcXport   = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  cdb_length;
        logic [15:0] data_length;
        logic        direction_in;
        logic [12:0] got_length;
        logic [7:0]  iu_id;
        logic [7:0]  iu_reserved;
        logic [15:0] iu_tag;
        logic [7:0]  scsi_status_in;
        logic [15:0] sense_length;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  pipe;
        logic [2:0]  result_code;
        logic [12:0] actual_bytes;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic        link_online;
        logic [7:0]  link_protocol;
        logic        streams_enabled;
        logic [11:0] timeout_ms;
    } cfg_t;

    // One result before it is placed in the output sequence.
    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  pipe;
        logic [2:0]  result_code;
        logic [12:0] actual_bytes;
    } res_t;

    // All results of one input word, up to three of them.
    typedef struct packed {
        logic [1:0]       count;
        res_t [2:0]       res;
    } plan_t;

    function automatic res_t mk_res(logic [1:0] action, logic [1:0] pipe,
                                    logic [2:0] code, logic [12:0] bytes);
        res_t r;
        r.action       = action;
        r.pipe         = pipe;
        r.result_code  = code;
        r.actual_bytes = bytes;
        return r;
    endfunction

    function automatic plan_t plan_add(plan_t p, res_t r);
        plan_t q;
        q = p;
        q.res[p.count] = r;
        q.count = p.count + 2'd1;
        return q;
    endfunction

endpackage

[rtl/core/uas_command_phase_sequencer_unit.sv]
// ============================================================================
// uas_command_phase_sequencer_unit: UAS single-tag command phase sequencer
// Top level: configuration registers, event front end, result queue and
// output sequencer.
// ============================================================================
// The block runs one USB Attached SCSI command (tag 1) at a time.
// Each input word is an event: a start request, a completion of the command,
// data or status pipe, a millisecond tick or a transport error. The front
// end takes one word per clock whenever the result queue has room, updates
// the command state in that same cycle, and queues the one to three result
// words the event causes (submit, abort, finish); events that cause nothing
// are consumed without a queue entry. The back end sends those result words
// one per clock while out_stall is low, through a registered output stage,
// with last set on the final word of each event. A busy event stream
// therefore sustains one input word per cycle for events without results
// and one output word per cycle while the output is not stalled; the output
// stage is the pacing point. Input stall rises only when the QUEUE_DEPTH
// entry queue is full. Configuration registers are written through a plain
// write port and must only change while the block is idle.
// ============================================================================
module uas_command_phase_sequencer_unit
    import uas_cps_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MaxDataBytesDefault,
    parameter int MAX_CDB_BYTES  = MaxCdbBytesDefault,
    parameter int QUEUE_DEPTH    = QueueDepthDefault
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_data,

    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  take;
    logic  push;
    plan_t push_plan;
    logic  q_full;
    logic  q_empty;
    logic  pop;
    plan_t head_plan;

    // Configuration registers, each written with the low bits of the data.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CfgLinkOnline:   cfg_next.link_online     = cfg_data[0];
                CfgLinkProtocol: cfg_next.link_protocol   = cfg_data[7:0];
                CfgStreams:      cfg_next.streams_enabled = cfg_data[0];
                CfgTimeout:      cfg_next.timeout_ms      = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_online     <= 1'b0;
            cfg_reg.link_protocol   <= UasProtocol;
            cfg_reg.streams_enabled <= 1'b0;
            cfg_reg.timeout_ms      <= TimeoutReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end only stalls when there is no room for a result list.
    assign in_stall = q_full;
    assign take     = in_valid && !in_stall;

    uas_cps_front #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES),
        .MAX_CDB_BYTES  (MAX_CDB_BYTES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .word  (in_data),
        .cfg   (cfg_reg),
        .push  (push),
        .plan  (push_plan)
    );

    uas_cps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_plan (push_plan),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head_plan (head_plan)
    );

    uas_cps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head_plan (head_plan),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[rtl/core/uas_cps_front.sv]
// ============================================================================
// uas_cps_front: event classification and command state
// Decodes one input word per cycle while take is high, updates the phase
// flags, counters and held status, and lists the results the word causes.
// ============================================================================
module uas_cps_front
    import uas_cps_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MaxDataBytesDefault,
    parameter int MAX_CDB_BYTES  = MaxCdbBytesDefault
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_word_t word,
    input  cfg_t     cfg,
    output logic     push,
    output plan_t    plan
);

    localparam int CmdIuBytes = 16 + MAX_CDB_BYTES;

    logic        busy_reg, busy_next;
    logic        cmd_fin_reg, cmd_fin_next;
    logic        data_begun_reg, data_begun_next;
    logic        data_fin_reg, data_fin_next;
    logic        status_fin_reg, status_fin_next;
    logic        dir_in_reg, dir_in_next;
    logic        has_data_reg, has_data_next;
    logic [12:0] moved_reg, moved_next;
    logic [11:0] elapsed_reg, elapsed_next;
    logic [7:0]  held_reg, held_next;

    logic        completion;
    logic        bad_request;
    logic        link_bad;
    logic        start_data;
    logic [1:0]  data_pipe;
    logic [7:0]  ready_id;
    logic [15:0] sense_room;
    plan_t       p;

    assign bad_request = (word.cdb_length == 8'd0)
                      || ({24'd0, word.cdb_length} > 32'(MAX_CDB_BYTES))
                      || ({16'd0, word.data_length} > 32'(MAX_DATA_BYTES));
    assign link_bad    = !cfg.link_online || (cfg.link_protocol != UasProtocol);
    assign start_data  = (word.data_length != 16'd0) && cfg.streams_enabled;
    assign data_pipe   = dir_in_reg ? PipeDataIn : PipeDataOut;
    assign ready_id    = dir_in_reg ? IuReadReady : IuWriteReady;
    assign sense_room  = {3'd0, word.got_length} - {3'd0, SenseHdrBytes};

    always_comb
    begin
        busy_next       = busy_reg;
        cmd_fin_next    = cmd_fin_reg;
        data_begun_next = data_begun_reg;
        data_fin_next   = data_fin_reg;
        status_fin_next = status_fin_reg;
        dir_in_next     = dir_in_reg;
        has_data_next   = has_data_reg;
        moved_next      = moved_reg;
        elapsed_next    = elapsed_reg;
        held_next       = held_reg;
        completion      = 1'b0;
        p               = '0;

        if (word.cmd == CmdStart)
        begin
            if (!busy_reg)
            begin
                if (bad_request)
                begin
                    p = plan_add(p, mk_res(ActFinish, PipeCommand, RcInvalid, 13'd0));
                end
                else if (link_bad)
                begin
                    p = plan_add(p, mk_res(ActFinish, PipeCommand, RcIoError, 13'd0));
                end
                else
                begin
                    busy_next       = 1'b1;
                    dir_in_next     = word.direction_in;
                    has_data_next   = (word.data_length != 16'd0);
                    cmd_fin_next    = 1'b0;
                    status_fin_next = 1'b0;
                    data_fin_next   = (word.data_length == 16'd0);
                    data_begun_next = start_data;
                    moved_next      = '0;
                    elapsed_next    = '0;
                    held_next       = '0;
                    p = plan_add(p, mk_res(ActSubmit, PipeStatus, RcOk, 13'd0));
                    if (start_data)
                    begin
                        p = plan_add(p, mk_res(ActSubmit,
                            word.direction_in ? PipeDataIn : PipeDataOut, RcOk, 13'd0));
                    end
                    p = plan_add(p, mk_res(ActSubmit, PipeCommand, RcOk, 13'd0));
                end
            end
        end
        else if (busy_reg)
        begin
            case (word.cmd)
                CmdCmdDone:
                begin
                    if (!cmd_fin_reg)
                    begin
                        if ({19'd0, word.got_length} != 32'(CmdIuBytes))
                        begin
                            p = plan_add(p, mk_res(ActAbort, PipeCommand, RcOk, 13'd0));
                            p = plan_add(p, mk_res(ActFinish, PipeCommand, RcIoError, 13'd0));
                            busy_next = 1'b0;
                        end
                        else
                        begin
                            cmd_fin_next = 1'b1;
                            completion   = 1'b1;
                        end
                    end
                end
                CmdDataDone:
                begin
                    if (data_begun_reg && !data_fin_reg)
                    begin
                        data_fin_next = 1'b1;
                        moved_next    = word.got_length;
                        completion    = 1'b1;
                    end
                end
                CmdStatusDone:
                begin
                    if (!status_fin_reg)
                    begin
                        if (word.got_length < StatusHdrBytes || word.iu_reserved != 8'd0
                            || word.iu_tag != CmdTag)
                        begin
                            p = plan_add(p, mk_res(ActAbort, PipeCommand, RcOk, 13'd0));
                            p = plan_add(p, mk_res(ActFinish, PipeCommand, RcIoError, 13'd0));
                            busy_next = 1'b0;
                        end
                        else if (word.iu_id == IuReadReady || word.iu_id == IuWriteReady)
                        begin
                            if (cfg.streams_enabled || !has_data_reg || data_begun_reg
                                || word.iu_id != ready_id)
                            begin
                                p = plan_add(p, mk_res(ActAbort, PipeCommand, RcOk, 13'd0));
                                p = plan_add(p, mk_res(ActFinish, PipeCommand, RcIoError,
                                                       13'd0));
                                busy_next = 1'b0;
                            end
                            else
                            begin
                                p = plan_add(p, mk_res(ActSubmit, PipeStatus, RcOk, 13'd0));
                                p = plan_add(p, mk_res(ActSubmit, data_pipe, RcOk, 13'd0));
                                data_begun_next = 1'b1;
                                completion      = 1'b1;
                            end
                        end
                        else if (word.iu_id == IuSense)
                        begin
                            if (word.got_length < SenseHdrBytes
                                || word.sense_length > sense_room)
                            begin
                                p = plan_add(p, mk_res(ActAbort, PipeCommand, RcOk, 13'd0));
                                p = plan_add(p, mk_res(ActFinish, PipeCommand, RcIoError,
                                                       13'd0));
                                busy_next = 1'b0;
                            end
                            else
                            begin
                                held_next       = word.scsi_status_in;
                                status_fin_next = 1'b1;
                                if (word.scsi_status_in != 8'd0 && !data_begun_reg)
                                begin
                                    data_fin_next = 1'b1;
                                end
                                if (word.scsi_status_in != 8'd0 && !data_fin_next)
                                begin
                                    p = plan_add(p, mk_res(ActAbort, PipeCommand, RcOk,
                                                           13'd0));
                                    p = plan_add(p, mk_res(ActFinish, PipeCommand,
                                                           RcIoError, 13'd0));
                                    busy_next = 1'b0;
                                end
                                else
                                begin
                                    completion = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            p = plan_add(p, mk_res(ActAbort, PipeCommand, RcOk, 13'd0));
                            p = plan_add(p, mk_res(ActFinish, PipeCommand, RcIoError, 13'd0));
                            busy_next = 1'b0;
                        end
                    end
                end
                CmdTick:
                begin
                    elapsed_next = elapsed_reg + 12'd1;
                    if (elapsed_next >= cfg.timeout_ms)
                    begin
                        p = plan_add(p, mk_res(ActAbort, PipeCommand, RcOk, 13'd0));
                        p = plan_add(p, mk_res(ActFinish, PipeCommand, RcTimeout, 13'd0));
                        busy_next = 1'b0;
                    end
                end
                CmdXportErr:
                begin
                    p = plan_add(p, mk_res(ActAbort, PipeCommand, RcOk, 13'd0));
                    p = plan_add(p, mk_res(ActFinish, PipeCommand, RcXport, 13'd0));
                    busy_next = 1'b0;
                end
                default:
                begin
                end
            endcase

            if (completion && busy_next && cmd_fin_next && status_fin_next && data_fin_next)
            begin
                p = plan_add(p, mk_res(ActFinish, PipeCommand,
                                       (held_next != 8'd0) ? RcIoError : RcOk, moved_next));
                busy_next = 1'b0;
            end
        end
    end

    assign plan = p;
    assign push = take && (p.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cmd_fin_reg    <= 1'b0;
            data_begun_reg <= 1'b0;
            data_fin_reg   <= 1'b0;
            status_fin_reg <= 1'b0;
            dir_in_reg     <= 1'b0;
            has_data_reg   <= 1'b0;
            moved_reg      <= '0;
            elapsed_reg    <= '0;
            held_reg       <= '0;
        end
        else if (take)
        begin
            busy_reg       <= busy_next;
            cmd_fin_reg    <= cmd_fin_next;
            data_begun_reg <= data_begun_next;
            data_fin_reg   <= data_fin_next;
            status_fin_reg <= status_fin_next;
            dir_in_reg     <= dir_in_next;
            has_data_reg   <= has_data_next;
            moved_reg      <= moved_next;
            elapsed_reg    <= elapsed_next;
            held_reg       <= held_next;
        end
    end

endmodule

[rtl/core/uas_cps_queue.sv]
// ============================================================================
// uas_cps_queue: result list queue between front and back
// A short first-in first-out store of result lists, one list per entry.
// ============================================================================
module uas_cps_queue
    import uas_cps_pkg::*;
#(
    parameter int DEPTH = QueueDepthDefault
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  plan_t push_plan,
    input  logic  pop,
    output logic  full,
    output logic  empty,
    output plan_t head_plan
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    plan_t            entry_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CntW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_plan = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_plan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // A push into a full queue would drop a result list.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result queue overflow");

    // An empty list is never stored.
    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_plan.count != 2'd0)
        else $error("empty result list pushed");

endmodule

[rtl/core/uas_cps_back.sv]
// ============================================================================
// uas_cps_back: result word sequencer
// Takes one result list at a time from the queue and hands its results to
// the output channel one word per cycle unless stalled, marking the final one.
// ============================================================================
module uas_cps_back
    import uas_cps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      empty,
    input  plan_t     head_plan,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    plan_t      plan_reg, plan_next;
    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic       at_last;
    logic       load;
    res_t       cur;

    assign cur     = plan_reg.res[idx_reg];
    assign at_last = (idx_reg == plan_reg.count - 2'd1);
    assign load    = !valid_reg || (!out_stall && at_last);
    assign pop     = load && !empty;

    always_comb
    begin
        plan_next  = plan_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = !empty;
            plan_next  = head_plan;
            idx_next   = '0;
        end
        else if (!out_stall)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign out_valid             = valid_reg;
    assign out_data.action       = cur.action;
    assign out_data.pipe         = cur.pipe;
    assign out_data.result_code  = cur.result_code;
    assign out_data.actual_bytes = cur.actual_bytes;
    assign out_data.last         = at_last;

    // An abort is always followed by the finish that carries its code.
    a_abort_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.action == ActAbort |-> !out_data.last)
        else $error("abort word marked last");

    // A finish always closes the sequence of its input word.
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.action == ActFinish |-> out_data.last)
        else $error("finish word not marked last");

    // Submit words carry no code and no byte count.
    a_submit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.action == ActSubmit
            |-> out_data.result_code == RcOk && out_data.actual_bytes == 13'd0)
        else $error("submit word carries a code or byte count");

endmodule

[sim/uas_command_phase_sequencer_checker.sv]
// ============================================================================
// uas_command_phase_sequencer_checker: result predictor and word comparator
// Watches the configuration port and both word channels of the sequencer,
// keeps its own copy of the command state, and checks every result word
// against the oldest predicted word.
// ============================================================================
module uas_command_phase_sequencer_checker
    import uas_cps_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MaxDataBytesDefault,
    parameter int MAX_CDB_BYTES  = MaxCdbBytesDefault
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,

    input  logic        in_valid,
    input  logic        in_stall,
    input  in_word_t    in_data,

    input  logic        out_valid,
    input  logic        out_stall,
    input  out_word_t   out_data,

    output int          fail_count,
    output int          pending
);

    // A command IU is a 16 byte header followed by the largest CDB.
    localparam int CmdIuBytes  = 16 + MAX_CDB_BYTES;
    localparam int ReportLimit = 10;

    logic        cfg_online;
    logic [7:0]  cfg_protocol;
    logic        cfg_streams;
    logic [11:0] cfg_timeout;

    logic        cmd_active;
    logic        cmd_phase_done;
    logic        data_armed;
    logic        data_phase_done;
    logic        status_phase_done;
    logic        xfer_dir_in;
    logic        xfer_has_data;
    logic [12:0] bytes_moved;
    logic [11:0] ms_elapsed;
    logic [7:0]  sense_status;

    out_word_t   expected_words[$];
    out_word_t   event_words[3];
    int          event_count;
    int          reports_made;

    function automatic logic [1:0] data_pipe();
        return xfer_dir_in ? PipeDataIn : PipeDataOut;
    endfunction

    task automatic add_word(input logic [1:0] action, input logic [1:0] pipe,
                            input logic [2:0] code, input logic [12:0] bytes);
        out_word_t w;
        w.action      = action;
        w.pipe        = pipe;
        w.result_code = code;
        w.actual_bytes = bytes;
        w.last        = 1'b0;
        event_words[event_count] = w;
        event_count++;
    endtask

    // Every error of a running command tears down the link and then reports the code.
    task automatic abort_with(input logic [2:0] code);
        add_word(ActAbort, PipeCommand, RcOk, '0);
        add_word(ActFinish, PipeCommand, code, '0);
        cmd_active = 1'b0;
    endtask

    task automatic predict_word(input in_word_t w);
        logic        completion;
        logic [12:0] got;
        event_count = 0;
        completion  = 1'b0;
        got         = w.got_length;
        if (w.cmd == CmdStart)
        begin
            if (!cmd_active)
            begin
                if (w.cdb_length == 0 || w.cdb_length > MAX_CDB_BYTES ||
                    w.data_length > MAX_DATA_BYTES)
                begin
                    add_word(ActFinish, PipeCommand, RcInvalid, '0);
                end
                else if (!cfg_online || cfg_protocol != UasProtocol)
                begin
                    add_word(ActFinish, PipeCommand, RcIoError, '0);
                end
                else
                begin
                    cmd_active        = 1'b1;
                    xfer_dir_in       = w.direction_in;
                    xfer_has_data     = (w.data_length != 0);
                    cmd_phase_done    = 1'b0;
                    status_phase_done = 1'b0;
                    data_phase_done   = !xfer_has_data;
                    data_armed        = 1'b0;
                    bytes_moved       = '0;
                    ms_elapsed        = '0;
                    sense_status      = '0;
                    add_word(ActSubmit, PipeStatus, RcOk, '0);
                    // With streams the data transfer is queued ahead of the command.
                    if (xfer_has_data && cfg_streams)
                    begin
                        add_word(ActSubmit, data_pipe(), RcOk, '0);
                        data_armed = 1'b1;
                    end
                    add_word(ActSubmit, PipeCommand, RcOk, '0);
                end
            end
        end
        else if (cmd_active)
        begin
            case (w.cmd)
                CmdCmdDone:
                begin
                    if (!cmd_phase_done)
                    begin
                        if (got != CmdIuBytes)
                        begin
                            abort_with(RcIoError);
                        end
                        else
                        begin
                            cmd_phase_done = 1'b1;
                            completion     = 1'b1;
                        end
                    end
                end
                CmdDataDone:
                begin
                    if (data_armed && !data_phase_done)
                    begin
                        data_phase_done = 1'b1;
                        bytes_moved     = got;
                        completion      = 1'b1;
                    end
                end
                CmdStatusDone:
                begin
                    if (!status_phase_done)
                    begin
                        if (got < StatusHdrBytes || w.iu_reserved != 0 ||
                            w.iu_tag != CmdTag)
                        begin
                            abort_with(RcIoError);
                        end
                        else if (w.iu_id == IuReadReady || w.iu_id == IuWriteReady)
                        begin
                            // A ready IU is only legal without streams, once, and
                            // in the direction of the data phase.
                            if (cfg_streams || !xfer_has_data || data_armed ||
                                w.iu_id != (xfer_dir_in ? IuReadReady : IuWriteReady))
                            begin
                                abort_with(RcIoError);
                            end
                            else
                            begin
                                add_word(ActSubmit, PipeStatus, RcOk, '0);
                                add_word(ActSubmit, data_pipe(), RcOk, '0);
                                data_armed = 1'b1;
                                completion = 1'b1;
                            end
                        end
                        else if (w.iu_id == IuSense)
                        begin
                            if (got < SenseHdrBytes ||
                                int'(w.sense_length) > int'(got) - int'(SenseHdrBytes))
                            begin
                                abort_with(RcIoError);
                            end
                            else
                            begin
                                sense_status      = w.scsi_status_in;
                                status_phase_done = 1'b1;
                                // A failing status before data started drops the
                                // data phase.
                                if (sense_status != 0 && !data_armed)
                                    data_phase_done = 1'b1;
                                if (sense_status != 0 && !data_phase_done)
                                    abort_with(RcIoError);
                                else
                                    completion = 1'b1;
                            end
                        end
                        else
                        begin
                            abort_with(RcIoError);
                        end
                    end
                end
                CmdTick:
                begin
                    ms_elapsed = ms_elapsed + 12'd1;
                    if (ms_elapsed >= cfg_timeout)
                        abort_with(RcTimeout);
                end
                CmdXportErr:
                begin
                    abort_with(RcXport);
                end
                default: ;
            endcase
            if (completion && cmd_active && cmd_phase_done && status_phase_done &&
                data_phase_done)
            begin
                add_word(ActFinish, PipeCommand, (sense_status != 0) ? RcIoError : RcOk,
                         bytes_moved);
                cmd_active = 1'b0;
            end
        end
        for (int i = 0; i < event_count; i++)
        begin
            event_words[i].last = (i == event_count - 1);
            expected_words.push_back(event_words[i]);
        end
    endtask

    task automatic check_word(input out_word_t seen);
        out_word_t want;
        if (expected_words.size() == 0)
        begin
            fail_count++;
            if (reports_made < ReportLimit)
                $display("unexpected: action=%0d pipe=%0d code=%0d bytes=%0d last=%0d",
                         seen.action, seen.pipe, seen.result_code, seen.actual_bytes,
                         seen.last);
            reports_made++;
        end
        else
        begin
            want = expected_words.pop_front();
            if (seen.action !== want.action || seen.pipe !== want.pipe ||
                seen.result_code !== want.result_code ||
                seen.actual_bytes !== want.actual_bytes || seen.last !== want.last)
            begin
                fail_count++;
                if (reports_made < ReportLimit)
                begin
                    $display("word mismatch");
                    $display("  expected action=%0d pipe=%0d code=%0d bytes=%0d last=%0d",
                             want.action, want.pipe, want.result_code, want.actual_bytes,
                             want.last);
                    $display("  actual   action=%0d pipe=%0d code=%0d bytes=%0d last=%0d",
                             seen.action, seen.pipe, seen.result_code, seen.actual_bytes,
                             seen.last);
                end
                reports_made++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_online        = 1'b0;
            cfg_protocol      = UasProtocol;
            cfg_streams       = 1'b0;
            cfg_timeout       = TimeoutReset;
            cmd_active        = 1'b0;
            cmd_phase_done    = 1'b0;
            data_armed        = 1'b0;
            data_phase_done   = 1'b0;
            status_phase_done = 1'b0;
            xfer_dir_in       = 1'b0;
            xfer_has_data     = 1'b0;
            bytes_moved       = '0;
            ms_elapsed        = '0;
            sense_status      = '0;
            expected_words.delete();
            fail_count        = 0;
            reports_made      = 0;
            pending          <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CfgLinkOnline:   cfg_online   = cfg_data[0];
                    CfgLinkProtocol: cfg_protocol = cfg_data[7:0];
                    CfgStreams:      cfg_streams  = cfg_data[0];
                    CfgTimeout:      cfg_timeout  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_word(in_data);
            if (out_valid && !out_stall)
                check_word(out_data);
            pending <= expected_words.size();
        end
    end

endmodule

[sim/uas_command_phase_sequencer_unit_tb.sv]
// ============================================================================
// uas_command_phase_sequencer_unit_tb: regression bench of the UAS sequencer
// Drives a short directed list of start requests and completion events, a
// backpressure burst, and then randomized command phases under changing
// link settings; a checker beside the block predicts and compares results.
// ============================================================================
module uas_command_phase_sequencer_unit_tb;
    import uas_cps_pkg::*;

    // Run limits. The cycle limit is far above the slowest legal run, in
    // which every word waits out the longest gaps on both sides.
    localparam int CycleLimit     = 400000;
    localparam int SettleCycles   = 16;
    localparam int LongHoldCycles = 120;
    localparam int RandomItems    = 275;
    localparam int TailItems      = 50;

    // A command IU is the 16 byte header plus the largest CDB.
    localparam int CmdIuBytes = 16 + MaxCdbBytesDefault;

    // Event code that no event uses; the block must drop it.
    localparam logic [2:0] CmdUnused = 3'd6;

    // Stages of one well-formed command, used to order its completions.
    localparam int StageCmd   = 0;
    localparam int StageReady = 1;
    localparam int StageData  = 2;
    localparam int StageSense = 3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_data;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int words_sent   = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int rx_burst     = 0;
    bit tx_idle;
    bit rx_idle;
    bit cur_streams;

    uas_command_phase_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    uas_command_phase_sequencer_checker phase_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("uas_command_phase_sequencer_unit regression: fail");
            $finish;
        end
    end

    // Result side. Stall comes in random bursts while idling is enabled.
    // When the stimulus asks for a long hold, this process counts it out
    // itself so that the sender keeps pushing words into a full block.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                out_stall <= 1'b1;
                repeat (LongHoldCycles) @(negedge clk);
            end
            else if (rx_burst > 0)
            begin
                rx_burst--;
                out_stall <= 1'b1;
            end
            else if (rx_idle && $urandom_range(0, 4) == 0)
            begin
                rx_burst = $urandom_range(0, 8);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // A word with every field random; the callers override what matters.
    function automatic in_word_t random_word();
        in_word_t w;
        w.cmd            = 3'($urandom_range(0, 7));
        w.cdb_length     = 8'($urandom);
        w.data_length    = 16'($urandom);
        w.direction_in   = 1'($urandom);
        w.got_length     = 13'($urandom);
        w.iu_id          = 8'($urandom);
        w.iu_reserved    = 8'($urandom);
        w.iu_tag         = 16'($urandom);
        w.scsi_status_in = 8'($urandom);
        w.sense_length   = 16'($urandom);
        return w;
    endfunction

    function automatic in_word_t event_word(input logic [2:0] code, input logic [12:0] got);
        in_word_t w;
        w            = random_word();
        w.cmd        = code;
        w.got_length = got;
        return w;
    endfunction

    function automatic in_word_t start_word(input logic [7:0] cdb, input logic [15:0] len,
                                            input logic dir);
        in_word_t w;
        w              = random_word();
        w.cmd          = CmdStart;
        w.cdb_length   = cdb;
        w.data_length  = len;
        w.direction_in = dir;
        return w;
    endfunction

    // A status completion carrying a well-formed IU header for tag one.
    function automatic in_word_t status_word(input logic [7:0] id, input logic [12:0] got,
                                             input logic [7:0] sst, input logic [15:0] slen);
        in_word_t w;
        w                = event_word(CmdStatusDone, got);
        w.iu_id          = id;
        w.iu_reserved    = '0;
        w.iu_tag         = CmdTag;
        w.scsi_status_in = sst;
        w.sense_length   = slen;
        return w;
    endfunction

    // Offers one word and returns at the falling edge after it was taken.
    // The word stays on the bus until the caller drives the next one.
    task automatic send_word(input in_word_t w);
        if (tx_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_data  <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        @(negedge clk);
    endtask

    // Stops offering words until every predicted result has come out, then
    // gives the block time to finish any event that produced no result.
    task automatic settle();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // All four registers are rewritten together, only while the block is quiet.
    task automatic set_config(input logic online, input logic [7:0] proto,
                              input logic streams, input logic [11:0] tmo);
        settle();
        write_reg(CfgLinkOnline, 12'(online));
        write_reg(CfgLinkProtocol, 12'(proto));
        write_reg(CfgStreams, 12'(streams));
        write_reg(CfgTimeout, tmo);
        cfg_we <= 1'b0;
        cur_streams = streams;
    endtask

    // One command: a start request followed by its completions in a legal
    // order, with stray ticks, noise words, duplicates and damaged headers
    // mixed in now and then.
    task automatic run_command();
        in_word_t    w;
        logic        dir;
        logic        has_data;
        logic [15:0] len;
        int          stages[$];
        int          moved;
        int          sgot;
        w              = random_word();
        w.cmd          = CmdStart;
        w.cdb_length   = ($urandom_range(0, 9) < 8) ?
                         8'($urandom_range(1, MaxCdbBytesDefault)) : 8'($urandom);
        case ($urandom_range(0, 9))
            0, 1:    w.data_length = '0;
            2:       w.data_length = 16'(MaxDataBytesDefault);
            3:       w.data_length = 16'($urandom);
            default: w.data_length = 16'($urandom_range(1, 512));
        endcase
        dir      = w.direction_in;
        len      = w.data_length;
        has_data = (w.data_length != 0);
        send_word(w);

        // Without streams the device has to ask for the data with a ready IU.
        if (has_data && !cur_streams)
            stages.push_back(StageReady);
        if (has_data)
            stages.push_back(StageData);
        stages.insert($urandom_range(0, stages.size()), StageCmd);
        stages.push_back(StageSense);
        // Sometimes the sense IU overtakes the other completions.
        if ($urandom_range(0, 9) == 0)
        begin
            sgot = stages.pop_back();
            stages.insert($urandom_range(0, stages.size()), sgot);
        end

        foreach (stages[i])
        begin
            if ($urandom_range(0, 5) == 0)
                send_word(event_word(CmdTick, 13'($urandom)));
            if ($urandom_range(0, 24) == 0)
                send_word(random_word());
            case (stages[i])
                StageCmd:
                begin
                    w = event_word(CmdCmdDone, 13'(CmdIuBytes));
                end
                StageReady:
                begin
                    w = status_word(dir ? IuReadReady : IuWriteReady,
                                    13'($urandom_range(4, 64)), 8'($urandom), 16'($urandom));
                end
                StageData:
                begin
                    moved = $urandom_range(0, 1) ? int'(len) :
                            $urandom_range(0, MaxDataBytesDefault);
                    w = event_word(CmdDataDone, 13'(moved));
                end
                default:
                begin
                    sgot = $urandom_range(16, 96);
                    w = status_word(IuSense, 13'(sgot),
                                    ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'd0,
                                    16'($urandom_range(0, sgot - 16)));
                end
            endcase
            case ($urandom_range(0, 19))
                0:       w.got_length  = 13'($urandom);
                1:       w.iu_reserved = 8'($urandom_range(1, 255));
                2:       w.iu_tag      = 16'($urandom);
                3:       w.iu_id       = 8'($urandom);
                default: ;
            endcase
            send_word(w);
            if ($urandom_range(0, 19) == 0)
                send_word(w);
        end
    endtask

    // A phase runs a few commands under one random setting and then sends
    // a transport error so that no command is left open across the rewrite.
    task automatic random_phase();
        logic        online;
        logic [7:0]  proto;
        logic        streams;
        logic [11:0] tmo;
        online  = ($urandom_range(0, 9) != 0);
        proto   = ($urandom_range(0, 7) != 0) ? UasProtocol : 8'($urandom);
        streams = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       tmo = '0;
            1:       tmo = 12'd1;
            2:       tmo = 12'd3;
            3:       tmo = '1;
            4:       tmo = 12'($urandom);
            default: tmo = 12'($urandom_range(20, 200));
        endcase
        set_config(online, proto, streams, tmo);
        repeat ($urandom_range(3, 8)) run_command();
        send_word(event_word(CmdXportErr, 13'($urandom)));
    endtask

    initial
    begin
        int first_random;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CfgLinkOnline;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        tx_idle   = 1'b1;
        rx_idle   = 1'b1;
        cur_streams = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings leave the link offline, so a good start reports an
        // I/O error without an abort, and an event while idle is dropped.
        send_word(start_word(8'd4, 16'd100, 1'b0));
        send_word(event_word(CmdTick, 13'($urandom)));

        set_config(1'b1, UasProtocol, 1'b0, 12'd2);
        // Malformed requests: empty CDB, CDB too long, data too long, all maxed.
        send_word(start_word(8'd0, 16'd16, 1'b1));
        send_word(start_word(8'(MaxCdbBytesDefault + 1), 16'd0, 1'b0));
        send_word(start_word(8'(MaxCdbBytesDefault), 16'(MaxDataBytesDefault + 1), 1'b1));
        send_word(start_word('1, '1, 1'b0));
        // A full-size read: ready IU, data, then a good sense IU.
        send_word(start_word(8'(MaxCdbBytesDefault), 16'(MaxDataBytesDefault), 1'b1));
        send_word(start_word(8'd1, 16'd0, 1'b0));
        send_word(event_word(CmdDataDone, 13'(MaxDataBytesDefault)));
        send_word(event_word(CmdCmdDone, 13'(CmdIuBytes)));
        send_word(event_word(CmdCmdDone, 13'(CmdIuBytes)));
        send_word(event_word(CmdUnused, 13'($urandom)));
        send_word(status_word(IuReadReady, StatusHdrBytes, 8'd0, 16'd0));
        send_word(event_word(CmdDataDone, 13'(MaxDataBytesDefault)));
        send_word(status_word(IuSense, SenseHdrBytes, 8'd0, 16'd0));
        // Two ticks against a limit of two time the command out.
        send_word(start_word(8'd1, 16'd0, 1'b0));
        send_word(event_word(CmdTick, 13'($urandom)));
        send_word(event_word(CmdTick, 13'($urandom)));
        // A sense IU whose sense data just fills it, with a failing status, then
        // the command completion finishes with an I/O error.
        send_word(start_word(8'd8, 16'd0, 1'b0));
        send_word(status_word(IuSense, 13'd600, 8'd2, 16'd584));
        send_word(event_word(CmdCmdDone, 13'(CmdIuBytes)));
        // Transport error, then a short command IU.
        send_word(start_word(8'd8, 16'd512, 1'b0));
        send_word(event_word(CmdXportErr, 13'($urandom)));
        send_word(start_word(8'd8, 16'd0, 1'b1));
        send_word(event_word(CmdCmdDone, 13'(CmdIuBytes - 1)));

        // Backpressure: the receiver holds off for a long stretch while
        // rejected starts keep producing one word each, so the result queue
        // fills and the input stalls. Afterwards the sender waits for all
        // of them to drain.
        set_config(1'b1, UasProtocol, 1'b0, TimeoutReset);
        holds_asked++;
        repeat (16) send_word(start_word(8'd0, 16'($urandom), 1'($urandom)));
        settle();

        // Random phases; the final stretch runs with no idling on either side.
        first_random = words_sent;
        while (words_sent - first_random < RandomItems)
        begin
            if (words_sent - first_random >= RandomItems - TailItems)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            else
            begin
                tx_idle = ($urandom_range(0, 9) < 7);
                rx_idle = ($urandom_range(0, 9) < 7);
            end
            random_phase();
        end

        settle();
        if (fail_count == 0)
            $display("uas_command_phase_sequencer_unit regression: pass");
        else
            $display("uas_command_phase_sequencer_unit regression: fail");
        $finish;
    end

endmodule
